// ===== hw/rtl/szc_pkg.sv =====
// Shared types and constants for the strip zero-suppression cluster finder.
package szc_pkg;

  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CNT_CFG_W   = 11;
  localparam int unsigned AMP_W       = 24;
  localparam int unsigned NB_W        = 4;
  localparam int unsigned STRIP_CAP   = 1024;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FIFO_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_COUNT     = 2'd2;

  localparam logic [AMP_W-1:0]     RST_HIT_THRESHOLD   = 24'd256;
  localparam logic [NB_W-1:0]      RST_NEIGHBOUR_COUNT = 4'd2;
  localparam logic [CNT_CFG_W-1:0] RST_STRIP_COUNT     = 11'd1024;

  typedef struct packed {
    logic [AMP_W-1:0]     hit_threshold;
    logic [NB_W-1:0]      neighbour_count;
    logic [CNT_CFG_W-1:0] strip_count;
  } szc_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] cluster_first;
    logic [IDX_W-1:0] cluster_final;
    logic             run_end;
  } szc_word_t;

  typedef struct packed {
    logic [1:0] count;
    szc_word_t  word0;
    szc_word_t  word1;
  } szc_push_t;

endpackage

// ===== hw/rtl/szc_cluster_core.sv =====
// Input register, window tracking and cluster emission for one strip per cycle while the queue has room.
module szc_cluster_core import szc_pkg::*; #(
  parameter int unsigned MAX_STRIPS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  szc_cfg_t         cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [AMP_W-1:0] amplitude_i,
  input  logic             space_ok_i,
  output szc_push_t        push_o
);

  localparam int unsigned LIMIT = (MAX_STRIPS < STRIP_CAP) ? MAX_STRIPS : STRIP_CAP;
  localparam logic [CNT_CFG_W-1:0] LIMIT_W = CNT_CFG_W'(LIMIT);

  logic             s1_valid_q;
  logic [AMP_W-1:0] amp_q;
  logic             fire;

  logic             win_open_q, win_open_d;
  logic [IDX_W-1:0] win_first_q, win_first_d;
  logic [IDX_W-1:0] win_final_q, win_final_d;
  logic [IDX_W-1:0] strip_index_q, strip_index_d;

  logic [CNT_CFG_W-1:0] eff_count;
  logic [CNT_CFG_W-1:0] last_w;
  logic [IDX_W-1:0]     last;
  logic                 is_last;
  logic [IDX_W-1:0]     j;
  logic [NB_W-1:0]      nb;
  logic                 hit;
  logic [IDX_W-1:0]     lo;
  logic [CNT_CFG_W-1:0] hi_w;
  logic [IDX_W-1:0]     hi;
  logic                 gap;
  logic                 emit_a;
  logic                 emit_b;
  logic                 open_n;
  logic [IDX_W-1:0]     first_n;
  logic [IDX_W-1:0]     final_n;
  szc_word_t            word_a;
  szc_word_t            word_b;

  assign fire       = s1_valid_q && space_ok_i;
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      amp_q <= amplitude_i;
    end
  end

  always_comb begin
    eff_count = cfg_i.strip_count;
    if (eff_count == '0) begin
      eff_count = CNT_CFG_W'(1);
    end
    if (eff_count > LIMIT_W) begin
      eff_count = LIMIT_W;
    end
    last_w = eff_count - CNT_CFG_W'(1);
    last   = last_w[IDX_W-1:0];

    is_last = {1'b0, strip_index_q} >= last_w;
    j       = is_last ? last : strip_index_q;
    nb      = cfg_i.neighbour_count;
    hit     = $signed(amp_q) > $signed(cfg_i.hit_threshold);

    lo   = (j > IDX_W'(nb)) ? (j - IDX_W'(nb)) : '0;
    hi_w = {1'b0, j} + CNT_CFG_W'(nb);
    hi   = (hi_w > last_w) ? last : hi_w[IDX_W-1:0];
    gap  = ({1'b0, win_final_q} + CNT_CFG_W'(nb) + CNT_CFG_W'(1)) < {1'b0, j};

    emit_a  = hit && win_open_q && gap;
    open_n  = win_open_q;
    first_n = win_first_q;
    final_n = win_final_q;
    if (hit) begin
      open_n  = 1'b1;
      final_n = hi;
      if (!win_open_q || gap) begin
        first_n = lo;
      end
    end
    emit_b = is_last && open_n;

    word_a.cluster_first = win_first_q;
    word_a.cluster_final = win_final_q;
    word_a.run_end       = !emit_b;
    word_b.cluster_first = first_n;
    word_b.cluster_final = final_n;
    word_b.run_end       = 1'b1;

    push_o.word0 = emit_a ? word_a : word_b;
    push_o.word1 = word_b;
    push_o.count = fire ? (2'(emit_a) + 2'(emit_b)) : 2'd0;

    if (is_last) begin
      win_open_d    = 1'b0;
      win_first_d   = '0;
      win_final_d   = '0;
      strip_index_d = '0;
    end else begin
      win_open_d    = open_n;
      win_first_d   = first_n;
      win_final_d   = final_n;
      strip_index_d = j + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_open_q    <= 1'b0;
      win_first_q   <= '0;
      win_final_q   <= '0;
      strip_index_q <= '0;
    end else if (fire) begin
      win_open_q    <= win_open_d;
      win_first_q   <= win_first_d;
      win_final_q   <= win_final_d;
      strip_index_q <= strip_index_d;
    end
  end

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_last |=> !win_open_q && strip_index_q == '0)
    else $error("window not closed after last strip");

  a_two_only_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> is_last && !push_o.word0.run_end && push_o.word1.run_end)
    else $error("two clusters outside ladder end");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_open_q |-> win_first_q <= win_final_q)
    else $error("open window has first beyond final");

endmodule

// ===== hw/rtl/szc_result_fifo.sv =====
// Result queue taking up to two cluster words per cycle and giving one while out_ready_i is high.
module szc_result_fifo import szc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  szc_push_t push_i,
  output logic      space_ok_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output szc_word_t word_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  szc_word_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign space_ok_o  = count_q <= CNT_W'(FIFO_DEPTH - 2);
  assign word_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.word0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.word1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> space_ok_o)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + CNT_W'($past(push_i.count)) - CNT_W'($past(pop)))
    else $error("queue count out of step");

endmodule

// ===== hw/rtl/strip_zero_suppress_clusterer.sv =====
// Top level of the strip zero-suppression cluster finder.
// One strip amplitude word is taken per clock, in strip order, while the queue
// has room; the strip index is counted inside and wraps after the last strip of
// the ladder. A word is held in the input register, then compared and merged
// into the open window; its clusters (none, one or two) enter a four-word result
// queue. The queue drains one cluster per cycle while out_ready_i is high, so a
// stalled output side holds the input once two free queue slots are no longer
// available. The user must write registers through the plain write port only
// while the block is idle; the block itself does not enforce this.
module strip_zero_suppress_clusterer import szc_pkg::*; #(
  parameter int unsigned MAX_STRIPS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [AMP_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [AMP_W-1:0]     amplitude_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_W-1:0]     cluster_first_o,
  output logic [IDX_W-1:0]     cluster_final_o,
  output logic                 run_end_o
);

  szc_cfg_t  cfg_q;
  szc_push_t push;
  szc_word_t word;
  logic      space_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_threshold   <= RST_HIT_THRESHOLD;
      cfg_q.neighbour_count <= RST_NEIGHBOUR_COUNT;
      cfg_q.strip_count     <= RST_STRIP_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HIT_THRESHOLD:   cfg_q.hit_threshold   <= cfg_data_i;
        REG_NEIGHBOUR_COUNT: cfg_q.neighbour_count <= cfg_data_i[NB_W-1:0];
        REG_STRIP_COUNT:     cfg_q.strip_count     <= cfg_data_i[CNT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  szc_cluster_core #(
    .MAX_STRIPS (MAX_STRIPS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .amplitude_i (amplitude_i),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  szc_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (word)
  );

  assign cluster_first_o = word.cluster_first;
  assign cluster_final_o = word.cluster_final;
  assign run_end_o       = word.run_end;

endmodule
